// ===== rtl/arcs_pkg.sv =====
package arcs_pkg;

  localparam int ADDR_W          = 32;
  localparam int PREFIX_W        = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
  } range_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   block_base;
    logic [PREFIX_W-1:0] prefix_length;
    logic [ADDR_W-1:0]   block_mask;
    logic                last_block;
  } block_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/arcs_front.sv =====
module arcs_front
  import arcs_pkg::*;
(
  input  logic      range_valid,
  output logic      range_ready,
  input  range_t    range_item,
  input  q_status_t qs,
  output logic      push,
  output range_t    push_item
);

  logic nonempty;

  // empty ranges are taken and dropped here
  assign nonempty    = range_item.range_start <= range_item.range_end;
  assign range_ready = !qs.full;
  assign push        = range_valid && range_ready && nonempty;
  assign push_item   = range_item;

endmodule

// ===== rtl/arcs_queue.sv =====
module arcs_queue
  import arcs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  range_t    push_item,
  input  logic      pop,
  output q_status_t qs,
  output range_t    head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  range_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign qs.full  = count == CNT_W'(DEPTH);
  assign qs.empty = count == '0;
  assign do_push  = push && !qs.full;
  assign do_pop   = pop && !qs.empty;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !qs.empty)
    else $error("pushed entry lost");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> !qs.full)
    else $error("queue full after pop");

endmodule

// ===== rtl/arcs_back.sv =====
module arcs_back
  import arcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_status_t qs,
  input  range_t    head,
  output logic      pop,
  output logic      block_valid,
  input  logic      block_ready,
  output block_t    block_item
);

  logic                busy;
  logic [ADDR_W-1:0]   cur;
  logic [ADDR_W:0]     rem;
  logic                adv;
  logic [ADDR_W-1:0]   smear;
  logic [ADDR_W-1:0]   hi_bit;
  logic [ADDR_W-1:0]   lo_bit;
  logic [ADDR_W-1:0]   size;
  logic [4:0]          size_log;
  logic                final_blk;

  // largest aligned block: min of lowest set bit of cursor and top bit of remainder
  always_comb begin
    smear = rem[ADDR_W-1:0];
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    if (rem[ADDR_W]) begin
      smear  = '1;
      hi_bit = {1'b1, {(ADDR_W-1){1'b0}}};
    end else begin
      hi_bit = smear & ~(smear >> 1);
    end
    if (cur == '0) begin
      lo_bit = {1'b1, {(ADDR_W-1){1'b0}}};
    end else begin
      lo_bit = cur & (~cur + ADDR_W'(1));
    end
    size = (|(lo_bit & smear)) ? lo_bit : hi_bit;
    size_log = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      if (size[i]) begin
        size_log = size_log | 5'(i);
      end
    end
  end

  assign final_blk = rem == {1'b0, size};
  assign adv       = busy && (!block_valid || block_ready);
  assign pop       = !busy && !qs.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      block_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (adv && final_blk) begin
        busy <= 1'b0;
      end
      if (adv) begin
        block_valid <= 1'b1;
      end else if (block_ready) begin
        block_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.range_start;
      rem <= {1'b0, head.range_end} - {1'b0, head.range_start} + (ADDR_W+1)'(1);
    end else if (adv) begin
      cur <= cur + size;
      rem <= rem - {1'b0, size};
    end
    if (adv) begin
      block_item.block_base    <= cur;
      block_item.prefix_length <= PREFIX_W'(ADDR_W) - {1'b0, size_log};
      block_item.block_mask    <= ~size + ADDR_W'(1);
      block_item.last_block    <= final_blk;
    end
  end

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0)
    else $error("active run with nothing left");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (adv && !final_blk) |=> busy)
    else $error("run ended before last block");

  a_block_aligned: assert property (@(posedge clk) disable iff (rst)
    block_valid |-> (block_item.block_base & ~block_item.block_mask) == '0)
    else $error("emitted block not aligned");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (adv && !final_blk) |-> !pop)
    else $error("new range loaded during a run");

endmodule

// ===== rtl/address_range_to_cidr_split_core.sv =====
// Splits each inclusive address range into its shortest ascending run of aligned
// power-of-two blocks, capped at /1, and emits one block per cycle while the
// output side keeps taking them. A single block-split engine loads a range from
// the input queue only while no run is in progress; the longest run has 62
// blocks. Ranges whose start exceeds their end are accepted and dropped without
// any output. Accepted ranges wait in a small queue (QUEUE_DEPTH entries), so
// the input keeps accepting while a run is being emitted until that queue fills.
// The last block of each run carries last_block set.
module address_range_to_cidr_split_core
  import arcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   range_valid,
  output logic   range_ready,
  input  range_t range_item,
  output logic   block_valid,
  input  logic   block_ready,
  output block_t block_item
);

  q_status_t qs;
  logic      push;
  range_t    push_item;
  logic      pop;
  range_t    head;

  arcs_front u_front (
    .range_valid (range_valid),
    .range_ready (range_ready),
    .range_item  (range_item),
    .qs          (qs),
    .push        (push),
    .push_item   (push_item)
  );

  arcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .qs        (qs),
    .head      (head)
  );

  arcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qs          (qs),
    .head        (head),
    .pop         (pop),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .block_item  (block_item)
  );

endmodule

// ===== tb/address_range_to_cidr_split_core_test.sv =====
module address_range_to_cidr_split_core_test
  import arcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int RANDOM_RANGES = 100;
  localparam int HOLD_START    = 200;
  localparam int HOLD_CYCLES   = 500;
  localparam int DRAIN_CYCLES  = 100;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PATTERN} ready_mode_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   range_valid = 1'b0;
  logic   range_ready;
  range_t range_item = '0;
  logic   block_valid;
  logic   block_ready = 1'b0;
  block_t block_item;

  range_t pending_ranges[$];
  block_t expected_blocks[$];
  block_t want;

  int errors = 0;
  int ranges_sent = 0;
  int empty_ranges = 0;
  int blocks_checked = 0;
  int longest_run = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int total_ranges = 0;
  int run_len;
  int made;
  ready_mode_t ready_mode = READY_ALWAYS;

  address_range_to_cidr_split_core u_top (
    .clk         (clk),
    .rst         (rst),
    .range_valid (range_valid),
    .range_ready (range_ready),
    .range_item  (range_item),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .block_item  (block_item)
  );

  always #5 clk = ~clk;

  // queues the aligned blocks covering one range, returns how many
  function automatic int push_cidr_blocks(range_t r);
    logic [ADDR_W:0]   cur;
    logic [ADDR_W:0]   nxt;
    logic [ADDR_W:0]   last;
    int                k;
    int                count;
    block_t            blk;
    logic              done;
    count = 0;
    if (r.range_start > r.range_end) return 0;
    cur  = {1'b0, r.range_start};
    last = {1'b0, r.range_end};
    done = 1'b0;
    while (!done) begin
      k = 0;
      while (k < ADDR_W - 1 && cur[k] == 1'b0 &&
             cur + (33'd1 << (k + 1)) - 33'd1 <= last) begin
        k++;
      end
      nxt = cur + (33'd1 << k);
      blk.block_base    = cur[ADDR_W-1:0];
      blk.prefix_length = PREFIX_W'(ADDR_W - k);
      blk.block_mask    = ALL_ONES << k;
      blk.last_block    = nxt > last;
      expected_blocks.insert(expected_blocks.size(), blk);
      count++;
      done = blk.last_block;
      cur  = nxt;
    end
    return count;
  endfunction

  function automatic range_t make_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    range_t r;
    r.range_start = lo;
    r.range_end   = hi;
    return r;
  endfunction

  function automatic void queue_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    pending_ranges.insert(pending_ranges.size(), make_range(lo, hi));
  endfunction

  function automatic range_t random_range();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] span;
    int                kind;
    int                k;
    kind = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    if (kind < 28) begin
      // wide range, long runs
      if (a > b) {a, b} = {b, a};
    end else if (kind < 50) begin
      span = $urandom_range(0, 600);
      b = (a > ALL_ONES - span) ? ALL_ONES : a + span;
    end else if (kind < 65) begin
      // one aligned block, sometimes trimmed at either side
      k = $urandom_range(0, 31);
      a = a & (ALL_ONES << k);
      b = a | ~(ALL_ONES << k);
      if (k > 2 && $urandom_range(0, 1)) b = b - $urandom_range(1, 3);
      if (k > 2 && $urandom_range(0, 1)) a = a + $urandom_range(1, 3);
    end else if (kind < 78) begin
      // anchored at the bottom or top of the space
      if ($urandom_range(0, 1)) begin
        a = 32'h0;
        b = b >> $urandom_range(0, 31);
      end else begin
        a = ~(ALL_ONES >> $urandom_range(0, 31)) | (a >> $urandom_range(1, 31));
        b = ALL_ONES;
      end
    end else if (kind < 92) begin
      span = $urandom >> $urandom_range(0, 31);
      b = (a > ALL_ONES - span) ? ALL_ONES : a + span;
    end else begin
      // empty range
      if (a < b) {a, b} = {b, a};
      if (a == b) begin
        if (a == ALL_ONES) b = a - 1;
        else a = a + 1;
      end
    end
    return make_range(a, b);
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      range_valid <= 1'b0;
    end else begin
      if (range_valid && range_ready) begin
        run_len = push_cidr_blocks(range_item);
        ranges_sent++;
        if (run_len == 0) empty_ranges++;
        if (run_len > longest_run) longest_run = run_len;
      end
      if (!range_valid || range_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          range_valid <= 1'b0;
        end else if (pending_ranges.size() > 0) begin
          range_item  <= pending_ranges.pop_front();
          range_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          range_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each block transaction, stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      block_ready <= 1'b0;
    end else begin
      cycle_count++;
      if (block_valid && block_ready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected block transaction, block_base %h", block_item.block_base);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (block_item.block_base !== want.block_base) begin
            $error("block_base expected %h got %h", want.block_base, block_item.block_base);
            errors++;
          end
          if (block_item.prefix_length !== want.prefix_length) begin
            $error("prefix_length expected %0d got %0d",
                   want.prefix_length, block_item.prefix_length);
            errors++;
          end
          if (block_item.block_mask !== want.block_mask) begin
            $error("block_mask expected %h got %h", want.block_mask, block_item.block_mask);
            errors++;
          end
          if (block_item.last_block !== want.last_block) begin
            $error("last_block expected %b got %b", want.last_block, block_item.last_block);
            errors++;
          end
        end
        blocks_checked++;
      end
      if (cycle_count == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        block_ready <= 1'b0;
      end else begin
        if (cycle_count % 128 == 0) ready_mode = ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
          READY_ALWAYS: block_ready <= 1'b1;
          READY_COIN:   block_ready <= 1'($urandom_range(0, 1));
          READY_MOSTLY: block_ready <= ($urandom_range(0, 7) != 0);
          default:      block_ready <= (cycle_count[2:0] != 3'b101) && !cycle_count[4];
        endcase
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    // full space, single addresses, empty ranges, longest run, bottom and top edges
    queue_range(32'h0, ALL_ONES);
    queue_range(32'h0, 32'h0);
    queue_range(ALL_ONES, ALL_ONES);
    queue_range(32'h1234_5679, 32'h1234_5679);
    queue_range(32'h1, 32'h0);
    queue_range(ALL_ONES, 32'h0);
    queue_range(32'h1, 32'hFFFF_FFFE);
    queue_range(32'h0, 32'hFFFF_FFFE);
    queue_range(32'h1, ALL_ONES);
    queue_range(32'h0, 32'h7FFF_FFFF);
    queue_range(32'h8000_0000, ALL_ONES);
    queue_range(32'h7FFF_FFFF, 32'h8000_0000);
    queue_range(32'h0, 32'h1);
    queue_range(32'h0, 32'h2);
    queue_range(32'h0, 32'h5);
    queue_range(32'hFFFF_FFFE, ALL_ONES);
    queue_range(32'h10, 32'h1F);
    queue_range(32'hAAAA_AAAA, 32'h5555_5555);
    queue_range(32'h5555_5555, 32'hAAAA_AAAA);
    queue_range(32'hC0A8_0001, 32'hC0A8_00FE);
    made = 0;
    while (made < RANDOM_RANGES) begin
      want.block_base = 0;
      pending_ranges.insert(pending_ranges.size(), random_range());
      if (pending_ranges[$].range_start <= pending_ranges[$].range_end) made++;
    end
    total_ranges = pending_ranges.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (ranges_sent < total_ranges || expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("split %0d ranges (%0d empty) into %0d checked blocks, longest run %0d",
             ranges_sent, empty_ranges, blocks_checked, longest_run);
    $display("sender bursts and gaps, receiver stalls and one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/arcs_pkg.sv
rtl/arcs_front.sv
rtl/arcs_queue.sv
rtl/arcs_back.sv
rtl/address_range_to_cidr_split_core.sv
tb/address_range_to_cidr_split_core_test.sv
